// ===== hw/rtl/pwst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_pkg
// Shared types and constants for the window slot table.
// ----------------------------------------------------------------------------
package pwst_pkg;

  localparam int SLOT_COUNT     = 16;
  localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ADDR_W         = 64;
  localparam int FLAG_W         = 8;
  localparam int FUNC_W         = 2;
  localparam int IDX_W          = 4;
  localparam int STRIDE_SHIFT   = 12;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 64;

  localparam logic [FLAG_W-1:0] LOCK_FLAG_MASK = FLAG_W'(4);

  localparam logic REG_WINDOW_BASE = 1'b0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_RESOLVE = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

// ===== hw/rtl/pwst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_if
// Request and response channels of the window slot table.
// ----------------------------------------------------------------------------
interface pwst_req_if;
  import pwst_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] phys_in;
  logic [ADDR_W-1:0] virt_in;
  logic [FLAG_W-1:0] flag_in;

  modport source (output valid, output func, output phys_in, output virt_in,
                  output flag_in, input ready);
  modport sink   (input valid, input func, input phys_in, input virt_in,
                  input flag_in, output ready);
endinterface

interface pwst_rsp_if;
  import pwst_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [IDX_W-1:0]  slot_index;
  logic [ADDR_W-1:0] window_virt;
  logic [ADDR_W-1:0] window_phys;
  logic [FLAG_W-1:0] window_flag;

  modport source (output valid, output status, output slot_index, output window_virt,
                  output window_phys, output window_flag, input ready);
  modport sink   (input valid, input status, input slot_index, input window_virt,
                  input window_phys, input window_flag, output ready);
endinterface

// ===== hw/rtl/phys_window_slot_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phys_window_slot_table_core
// Window slot table: create, release and resolve over a fixed set of slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. After the request transfer, one slot is
// examined per cycle by a single shared 64-bit compare unit, starting at slot
// zero and stopping at the first hit (or at the last slot); an unused
// operation code ends the scan at slot zero with a miss. The response sits in
// an output register, so a new request can be taken while the previous
// response still waits; a scan only stalls on its final cycle if that register
// is still occupied. window_base is written through the APB port at address 0
// and must only change while idle.
module phys_window_slot_table_core (
  input  logic                        clk,
  input  logic                        rst,
  pwst_req_if.sink                    req,
  pwst_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pwst_pkg::CFG_AW-1:0] paddr,
  input  logic [pwst_pkg::CFG_DW-1:0] pwdata,
  output logic [pwst_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import pwst_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] window_base;

  logic [FUNC_W-1:0] op_func;
  logic [ADDR_W-1:0] op_phys;
  logic [ADDR_W-1:0] op_virt;
  logic [FLAG_W-1:0] op_flag;
  logic [SLOT_W-1:0] scan_idx;

  logic [ADDR_W-1:0] slot_virt  [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_phys  [SLOT_COUNT];
  logic [FLAG_W-1:0] slot_flags [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [SLOT_COUNT-1:0] slot_locked;

  logic              out_valid;
  logic              out_status;
  logic [IDX_W-1:0]  out_idx;
  logic [ADDR_W-1:0] out_virt;
  logic [ADDR_W-1:0] out_phys;
  logic [FLAG_W-1:0] out_flag;

  logic [ADDR_W-1:0] cur_virt;
  logic [ADDR_W-1:0] cur_phys;
  logic [FLAG_W-1:0] cur_flag;
  logic [ADDR_W-1:0] create_virt;
  logic              hit;
  logic              op_bad;
  logic              last;
  logic              finish;
  logic              out_free;
  logic              commit;
  logic              accept;
  logic              cfg_write;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign prdata    = (paddr[CFG_AW-1] == REG_WINDOW_BASE) ? window_base : '0;

  // shared slot read and compare unit
  assign cur_virt    = slot_valid[scan_idx] ? slot_virt[scan_idx]  : '0;
  assign cur_phys    = slot_valid[scan_idx] ? slot_phys[scan_idx]  : '0;
  assign cur_flag    = slot_valid[scan_idx] ? slot_flags[scan_idx] : '0;
  assign create_virt = window_base
                     + {{(ADDR_W-SLOT_W-STRIDE_SHIFT){1'b0}}, scan_idx,
                        {STRIDE_SHIFT{1'b0}}};
  assign last        = (scan_idx == SLOT_W'(SLOT_COUNT - 1));

  always_comb begin
    hit    = 1'b0;
    op_bad = 1'b0;
    case (op_func) inside
      FUNC_CREATE:                hit = ~slot_locked[scan_idx];
      FUNC_RELEASE, FUNC_RESOLVE: hit = (cur_virt == op_virt);
      default:                    op_bad = 1'b1;
    endcase
  end

  assign out_free = ~out_valid | rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) state_next = ST_SCAN;
      ST_SCAN: if (finish && out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    finish    = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: finish = hit | last | op_bad;
      default: req.ready = 1'b0;
    endcase
  end

  assign accept = req.valid & req.ready;
  assign commit = finish & out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_base <= '0;
      slot_valid  <= '0;
      slot_locked <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && paddr[CFG_AW-1] == REG_WINDOW_BASE) begin
        window_base <= pwdata;
      end
      if (commit && hit) begin
        if (op_func == FUNC_CREATE) begin
          slot_valid[scan_idx]  <= 1'b1;
          slot_locked[scan_idx] <= ((op_flag & LOCK_FLAG_MASK) == LOCK_FLAG_MASK);
        end else if (op_func == FUNC_RELEASE) begin
          slot_locked[scan_idx] <= 1'b0;
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request hold, scan index, slot payload and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= req.func;
      op_phys  <= req.phys_in;
      op_virt  <= req.virt_in;
      op_flag  <= req.flag_in;
      scan_idx <= '0;
    end else if (state == ST_SCAN && !finish) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
    if (commit && hit && op_func == FUNC_CREATE) begin
      slot_virt[scan_idx]  <= create_virt;
      slot_phys[scan_idx]  <= op_phys;
      slot_flags[scan_idx] <= op_flag;
    end
    if (commit) begin
      out_status <= hit ? STATUS_OK : STATUS_MISS;
      out_idx    <= hit ? IDX_W'(scan_idx) : '0;
      out_virt   <= !hit ? '0 : (op_func == FUNC_CREATE) ? create_virt : cur_virt;
      out_phys   <= (hit && op_func == FUNC_RESOLVE) ? cur_phys : '0;
      out_flag   <= (hit && op_func == FUNC_RESOLVE) ? cur_flag : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot_index  = out_idx;
  assign rsp.window_virt = out_virt;
  assign rsp.window_phys = out_phys;
  assign rsp.window_flag = out_flag;

endmodule

// ===== hw/rtl/pwst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_port_checker
// Port-level checks for the window slot table, bound to the table core.
// ----------------------------------------------------------------------------
module pwst_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        status,
  input logic [pwst_pkg::IDX_W-1:0]  slot_index,
  input logic [pwst_pkg::ADDR_W-1:0] window_virt,
  input logic [pwst_pkg::ADDR_W-1:0] window_phys,
  input logic [pwst_pkg::FLAG_W-1:0] window_flag
);
  import pwst_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(window_virt) && $stable(status))
    else $error("response changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_MISS |->
      slot_index == '0 && window_virt == '0 && window_phys == '0 && window_flag == '0)
    else $error("miss response carries nonzero fields");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a scan is running");

  a_rsp_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared without a scan");

endmodule

bind phys_window_slot_table_core pwst_port_checker u_pwst_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .slot_index  (rsp.slot_index),
  .window_virt (rsp.window_virt),
  .window_phys (rsp.window_phys),
  .window_flag (rsp.window_flag)
);
